// File: design/fcpt_pkg.sv
// ----------------------------------------------------------------------------
// fcpt_pkg: shared types of the function call profile table
// Operation and status codes and the request and token bundles that are
// passed to and along the chain of table cells.
// ----------------------------------------------------------------------------
package fcpt_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam int ADDR_W      = 48;
  localparam int TIME_W      = 48;
  localparam int CALLS_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int FUNC_W      = 2;

  typedef enum logic [1:0] {
    OP_ENTER,
    OP_EXIT,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_ENTER_HIT,
    ST_ENTER_NEW,
    ST_FULL,
    ST_EXIT_OK,
    ST_EXIT_MISS,
    ST_READ_OK,
    ST_READ_EMPTY
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_BUSY
  } fsm_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  key;
    logic [TIME_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    status_t            status;
    logic [INDEX_W-1:0] idx;
    logic [CALLS_W-1:0] calls;
    logic [TIME_W-1:0]  shortest;
    logic [TIME_W-1:0]  longest;
  } tok_t;

endpackage

// File: design/fcpt_cell.sv
// ----------------------------------------------------------------------------
// fcpt_cell: one entry of the profile table
// Holds one entry and processes the request token as it passes by, then
// hands the token to the next cell.
// ----------------------------------------------------------------------------
module fcpt_cell #(
  parameter int CELL_IDX = 0,
  parameter int USED_W   = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  fcpt_pkg::req_t        req,
  input  logic [USED_W-1:0]     used,
  input  logic [fcpt_pkg::INDEX_W-1:0] ridx,
  input  fcpt_pkg::tok_t        tok_in,
  output fcpt_pkg::tok_t        tok_out
);
  import fcpt_pkg::*;

  localparam int CMP_W = USED_W + INDEX_W;

  logic [ADDR_W-1:0]  key_r,   key_nxt;
  logic [CALLS_W-1:0] count_r, count_nxt;
  logic [TIME_W-1:0]  begin_r, begin_nxt;
  logic [TIME_W-1:0]  min_r,   min_nxt;
  logic [TIME_W-1:0]  max_r,   max_nxt;
  logic               upd;
  tok_t               tok_r,   tok_nxt;

  logic               occ;
  logic               hit;
  logic               at_free;
  logic               at_ridx;
  logic [TIME_W-1:0]  elapsed;

  assign occ     = CMP_W'(CELL_IDX) < CMP_W'(used);
  assign at_free = CMP_W'(CELL_IDX) == CMP_W'(used);
  assign at_ridx = CMP_W'(CELL_IDX) == CMP_W'(ridx);
  assign hit     = occ && (key_r == req.key);
  assign elapsed = req.now - begin_r;

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    begin_nxt = begin_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    upd       = 1'b0;
    tok_nxt   = tok_in;
    if (tok_in.valid && !tok_in.done) begin
      case (req.op)
        OP_ENTER: begin
          if (hit) begin
            count_nxt = (count_r == '1) ? count_r : count_r + CALLS_W'(1);
            begin_nxt = req.now;
            upd       = 1'b1;
            tok_nxt.done     = 1'b1;
            tok_nxt.status   = ST_ENTER_HIT;
            tok_nxt.idx      = INDEX_W'(CELL_IDX);
            tok_nxt.calls    = count_nxt;
            tok_nxt.shortest = min_r;
            tok_nxt.longest  = max_r;
          end else if (at_free) begin
            key_nxt   = req.key;
            count_nxt = CALLS_W'(1);
            begin_nxt = req.now;
            min_nxt   = '1;
            max_nxt   = '0;
            upd       = 1'b1;
            tok_nxt.done     = 1'b1;
            tok_nxt.status   = ST_ENTER_NEW;
            tok_nxt.idx      = INDEX_W'(CELL_IDX);
            tok_nxt.calls    = count_nxt;
            tok_nxt.shortest = min_nxt;
            tok_nxt.longest  = max_nxt;
          end
        end
        OP_EXIT: begin
          if (hit) begin
            min_nxt = (elapsed < min_r) ? elapsed : min_r;
            max_nxt = (elapsed > max_r) ? elapsed : max_r;
            upd     = 1'b1;
            tok_nxt.done     = 1'b1;
            tok_nxt.status   = ST_EXIT_OK;
            tok_nxt.idx      = INDEX_W'(CELL_IDX);
            tok_nxt.calls    = count_r;
            tok_nxt.shortest = min_nxt;
            tok_nxt.longest  = max_nxt;
          end
        end
        default: begin
          if (occ && at_ridx) begin
            tok_nxt.done     = 1'b1;
            tok_nxt.status   = ST_READ_OK;
            tok_nxt.idx      = INDEX_W'(CELL_IDX);
            tok_nxt.calls    = count_r;
            tok_nxt.shortest = min_r;
            tok_nxt.longest  = max_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en && upd) begin
      key_r   <= key_nxt;
      count_r <= count_nxt;
      begin_r <= begin_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: design/function_call_profile_table_top.sv
// ----------------------------------------------------------------------------
// function_call_profile_table_top: hardware function call profiler
// Table of per-function call counts and shortest and longest elapsed times,
// built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each transfer on the input starts a token that walks the chain of ENTRIES
// cells, one cell per cycle while a stalled output does not hold the chain;
// the token is registered in start_r, in each cell and then in the output
// register, and the block takes one item at a time. While a finished result
// is held on a stalled output, a second result waits at the end of the chain
// until the first one is transferred.
module function_call_profile_table_top #(
  parameter int ENTRIES = fcpt_pkg::DEF_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcpt_pkg::FUNC_W-1:0]   in_func,
  input  logic [fcpt_pkg::ADDR_W-1:0]   in_fn_address,
  input  logic [fcpt_pkg::TIME_W-1:0]   in_timestamp,
  input  logic [fcpt_pkg::INDEX_W-1:0]  in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [fcpt_pkg::INDEX_W-1:0]  out_entry_index,
  output logic [fcpt_pkg::CALLS_W-1:0]  out_calls,
  output logic [fcpt_pkg::TIME_W-1:0]   out_shortest,
  output logic [fcpt_pkg::TIME_W-1:0]   out_longest
);
  import fcpt_pkg::*;

  localparam int USED_W = $clog2(ENTRIES + 1);

  fsm_t               state_r, state_nxt;
  req_t               req_r,   req_nxt;
  logic [INDEX_W-1:0] ridx_r,  ridx_nxt;
  logic [USED_W-1:0]  used_r,  used_nxt;
  logic               start_r, start_nxt;
  tok_t               out_r,   out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               en;
  logic               finish;
  tok_t               fin;
  tok_t               chain [0:ENTRIES];
  op_t                op_in;

  always_comb begin
    case (in_func)
      FUNC_W'(OP_ENTER): op_in = OP_ENTER;
      FUNC_W'(OP_EXIT):  op_in = OP_EXIT;
      default:           op_in = OP_READ;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign en     = !(chain[ENTRIES].valid && out_valid_r && out_stall);
  assign finish = chain[ENTRIES].valid && en;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start_r;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    fcpt_cell #(
      .CELL_IDX (g),
      .USED_W   (USED_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .req     (req_r),
      .used    (used_r),
      .ridx    (ridx_r),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  always_comb begin
    fin = chain[ENTRIES];
    if (!fin.done) begin
      fin.idx      = '0;
      fin.calls    = '0;
      fin.shortest = '0;
      fin.longest  = '0;
      case (req_r.op)
        OP_ENTER: fin.status = ST_FULL;
        OP_EXIT:  fin.status = ST_EXIT_MISS;
        default: begin
          fin.status = ST_READ_EMPTY;
          fin.idx    = ridx_r;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (accept) state_nxt = FSM_BUSY;
      FSM_BUSY: if (finish) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != FSM_IDLE);
    req_nxt   = req_r;
    ridx_nxt  = ridx_r;
    start_nxt = en ? 1'b0 : start_r;
    used_nxt  = used_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      req_nxt.op  = op_in;
      req_nxt.key = in_fn_address;
      req_nxt.now = in_timestamp;
      ridx_nxt    = in_read_index;
      start_nxt   = 1'b1;
    end
    if (finish) begin
      out_nxt       = fin;
      out_valid_nxt = 1'b1;
      if (fin.status == ST_ENTER_NEW) begin
        used_nxt = used_r + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      start_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    ridx_r <= ridx_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_entry_index = out_r.idx;
  assign out_calls       = out_r.calls;
  assign out_shortest    = out_r.shortest;
  assign out_longest     = out_r.longest;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(ENTRIES))
    else $error("occupied count exceeds table depth");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[ENTRIES].valid |-> state_r == FSM_BUSY)
    else $error("token at chain end while idle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && fin.status == ST_ENTER_NEW) |=> used_r == $past(used_r) + USED_W'(1))
    else $error("insert did not grow the table");

  a_full_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && fin.status == ST_FULL) |-> used_r == USED_W'(ENTRIES))
    else $error("table reported full while entries remain");
`endif

endmodule

// File: tb/sv/fcpt_profile_checker.sv
// ----------------------------------------------------------------------------
// fcpt_profile_checker: result checker for the function call profile table
// Watches both channels, keeps its own copy of the profile table, predicts
// the result of every input transfer and compares each result transfer with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fcpt_profile_checker #(
  parameter int ENTRIES = fcpt_pkg::DEF_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [fcpt_pkg::FUNC_W-1:0]   in_func,
  input  logic [fcpt_pkg::ADDR_W-1:0]   in_fn_address,
  input  logic [fcpt_pkg::TIME_W-1:0]   in_timestamp,
  input  logic [fcpt_pkg::INDEX_W-1:0]  in_read_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [2:0]                    out_status,
  input  logic [fcpt_pkg::INDEX_W-1:0]  out_entry_index,
  input  logic [fcpt_pkg::CALLS_W-1:0]  out_calls,
  input  logic [fcpt_pkg::TIME_W-1:0]   out_shortest,
  input  logic [fcpt_pkg::TIME_W-1:0]   out_longest,
  output int                            mismatch_count,
  output int                            results_owed
);
  import fcpt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] idx;
    logic [CALLS_W-1:0] calls;
    logic [TIME_W-1:0]  shortest;
    logic [TIME_W-1:0]  longest;
  } profile_result_t;

  logic [ADDR_W-1:0]  key_tab   [ENTRIES];
  logic [CALLS_W-1:0] calls_tab [ENTRIES];
  logic [TIME_W-1:0]  start_tab [ENTRIES];
  logic [TIME_W-1:0]  short_tab [ENTRIES];
  logic [TIME_W-1:0]  long_tab  [ENTRIES];
  int                 occupied;
  int                 errors;
  profile_result_t    predicted_results [$];
  profile_result_t    oldest;

  function automatic profile_result_t entry_view(status_t status, int slot);
    profile_result_t r;
    r.status   = status;
    r.idx      = slot[INDEX_W-1:0];
    r.calls    = calls_tab[slot];
    r.shortest = short_tab[slot];
    r.longest  = long_tab[slot];
    return r;
  endfunction

  function automatic profile_result_t profile_event(logic [FUNC_W-1:0] func,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [TIME_W-1:0] stamp,
                                                    logic [INDEX_W-1:0] ridx);
    profile_result_t r;
    int              slot;
    int              i;
    logic [TIME_W-1:0] span;
    r = '0;
    slot = -1;
    for (i = 0; i < occupied; i++) begin
      if (slot < 0 && key_tab[i] == addr) begin
        slot = i;
      end
    end
    if (func == OP_ENTER) begin
      if (slot >= 0) begin
        if (calls_tab[slot] != '1) begin
          calls_tab[slot] = calls_tab[slot] + 1'b1;
        end
        start_tab[slot] = stamp;
        r = entry_view(ST_ENTER_HIT, slot);
      end else if (occupied < ENTRIES) begin
        key_tab[occupied]   = addr;
        calls_tab[occupied] = CALLS_W'(1);
        start_tab[occupied] = stamp;
        short_tab[occupied] = '1;
        long_tab[occupied]  = '0;
        occupied++;
        r = entry_view(ST_ENTER_NEW, occupied - 1);
      end else begin
        r.status = ST_FULL;
      end
    end else if (func == OP_EXIT) begin
      if (slot >= 0) begin
        span = stamp - start_tab[slot];
        if (span < short_tab[slot]) begin
          short_tab[slot] = span;
        end
        if (span > long_tab[slot]) begin
          long_tab[slot] = span;
        end
        r = entry_view(ST_EXIT_OK, slot);
      end else begin
        r.status = ST_EXIT_MISS;
      end
    end else begin
      if (int'(ridx) < occupied) begin
        r = entry_view(ST_READ_OK, int'(ridx));
      end else begin
        r.status = ST_READ_EMPTY;
        r.idx    = ridx;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      occupied = 0;
      errors   = 0;
      predicted_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(profile_event(in_func, in_fn_address,
                                                  in_timestamp, in_read_index));
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("status: expected no transfer, got 0x%0h", out_status);
          errors++;
        end else begin
          oldest = predicted_results.pop_front();
          check_field("status", TIME_W'(oldest.status), TIME_W'(out_status));
          check_field("entry_index", TIME_W'(oldest.idx), TIME_W'(out_entry_index));
          check_field("calls", TIME_W'(oldest.calls), TIME_W'(out_calls));
          check_field("shortest", oldest.shortest, out_shortest);
          check_field("longest", oldest.longest, out_longest);
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= predicted_results.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the function call profile table
// Drives directed and random enter, exit and read events with random idle
// and stall patterns, fills the table to overflow, and gives the verdict
// from the failure count of the checker and the results still owed.
// ----------------------------------------------------------------------------
module tb_top;
  import fcpt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;
  localparam logic [ADDR_W-1:0] ALL_ONES     = '1;
  localparam logic [ADDR_W-1:0] ALT_LOW      = 48'h5555_5555_5555;
  localparam logic [ADDR_W-1:0] ALT_HIGH     = 48'hAAAA_AAAA_AAAA;
  localparam int                KEY_POOL     = 600;
  localparam int                RANDOM_ITEMS = 1530;
  localparam int                PHASE_LEN    = 510;
  localparam int                HOLD_CYCLES  = 1200;
  localparam int                DRAIN_CYCLES = 600;
  localparam int                CYCLE_LIMIT  = 3000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func;
  logic [ADDR_W-1:0]   in_fn_address;
  logic [TIME_W-1:0]   in_timestamp;
  logic [INDEX_W-1:0]  in_read_index;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          out_status;
  logic [INDEX_W-1:0]  out_entry_index;
  logic [CALLS_W-1:0]  out_calls;
  logic [TIME_W-1:0]   out_shortest;
  logic [TIME_W-1:0]   out_longest;
  int                  mismatch_count;
  int                  results_owed;

  int                  tx_pct;
  int                  rx_pct;
  logic                hold_req;
  int                  cycles = 0;
  logic [ADDR_W-1:0]   key_pool [KEY_POOL];

  function_call_profile_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_fn_address   (in_fn_address),
    .in_timestamp    (in_timestamp),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_calls       (out_calls),
    .out_shortest    (out_shortest),
    .out_longest     (out_longest)
  );

  fcpt_profile_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_fn_address   (in_fn_address),
    .in_timestamp    (in_timestamp),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_calls       (out_calls),
    .out_shortest    (out_shortest),
    .out_longest     (out_longest),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** function_call_profile_table_top: FAILED **");
      $finish;
    end
  end

  // The result side stalls at random, and on request holds off for a long
  // stretch so that the table backs up and stalls its input.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  task automatic offer(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                       logic [TIME_W-1:0] stamp, logic [INDEX_W-1:0] ridx);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_fn_address <= addr;
    in_timestamp  <= stamp;
    in_read_index <= ridx;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  stamp;
    logic [TIME_W-1:0]  now_us;
    logic [INDEX_W-1:0] ridx;
    int                 next_fresh;
    int                 pick;
    int                 read_top;
    int                 n;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = OP_ENTER;
    in_fn_address = '0;
    in_timestamp  = '0;
    in_read_index = '0;
    hold_req      = 1'b0;
    tx_pct        = 0;
    rx_pct        = 0;
    now_us        = '0;
    next_fresh    = 0;
    for (n = 0; n < KEY_POOL; n++) begin
      key_pool[n] = rand48();
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(OP_READ, '0, '0, 8'h00);
    offer(FUNC_SPARE, ALL_ONES, ALL_ONES, 8'hFF);
    offer(OP_EXIT, '0, 48'd5, 8'h00);
    offer(OP_ENTER, '0, '0, 8'h00);
    offer(OP_ENTER, ALL_ONES, ALL_ONES, 8'hFF);
    offer(OP_ENTER, '0, 48'd100, 8'h00);
    offer(OP_EXIT, '0, 48'd50, 8'h00);
    offer(OP_EXIT, '0, 48'd130, 8'h00);
    offer(OP_EXIT, ALL_ONES, 48'd5, 8'hFF);
    offer(OP_EXIT, ALL_ONES, ALL_ONES - 1'b1, 8'hFF);
    offer(OP_ENTER, ALT_LOW, ALT_HIGH, 8'h55);
    offer(OP_EXIT, ALT_LOW, ALT_HIGH, 8'h55);
    offer(OP_EXIT, 48'h1234, ALT_LOW, 8'hAA);
    offer(OP_READ, ALT_HIGH, ALT_LOW, 8'd0);
    offer(FUNC_SPARE, ALT_LOW, ALT_HIGH, 8'd1);
    offer(OP_READ, '0, '0, 8'd2);
    offer(OP_READ, '0, '0, 8'd3);
    offer(OP_READ, '0, '0, 8'h80);
    offer(OP_ENTER, ALT_HIGH, ALT_LOW, 8'hAA);
    offer(OP_ENTER, ALL_ONES, '0, 8'h00);

    tx_pct = 34;
    rx_pct = 78;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PHASE_LEN) begin
        tx_pct   = 78;
        rx_pct   = 34;
        hold_req = 1'b1;
      end
      if (n == 2 * PHASE_LEN) begin
        tx_pct = 0;
        rx_pct = 0;
        in_valid <= 1'b0;
        while (results_owed != 0) begin
          @(negedge clk);
        end
      end
      now_us = now_us + 48'($urandom_range(1, 4000));
      stamp  = ($urandom_range(9) == 0) ? rand48() : now_us;
      ridx   = 8'($urandom_range(255));
      pick   = $urandom_range(99);
      if (pick < 50) begin
        if (next_fresh == 0 || (next_fresh < KEY_POOL && $urandom_range(1) == 0)) begin
          addr = key_pool[next_fresh];
          next_fresh++;
        end else begin
          addr = key_pool[$urandom_range(next_fresh - 1)];
        end
        offer(OP_ENTER, addr, stamp, ridx);
      end else if (pick < 85) begin
        if (next_fresh == 0 || $urandom_range(9) == 0) begin
          addr = rand48();
        end else begin
          addr = key_pool[$urandom_range(next_fresh - 1)];
        end
        offer(OP_EXIT, addr, stamp, ridx);
      end else begin
        if ($urandom_range(1) == 0) begin
          read_top = (next_fresh + 4 > 255) ? 255 : next_fresh + 4;
          ridx = 8'($urandom_range(read_top));
        end
        offer(($urandom_range(1) == 0) ? OP_READ : FUNC_SPARE, rand48(), stamp, ridx);
      end
    end
    in_valid <= 1'b0;

    while (results_owed != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("** function_call_profile_table_top: PASSED **");
    end else begin
      $display("** function_call_profile_table_top: FAILED **");
    end
    $finish;
  end

endmodule
